// File: rtl/mtwd_pkg.sv
package mtwd_pkg;

    // Action codes of an input item
    localparam logic [2:0] ACT_REGISTER    = 3'd0;
    localparam logic [2:0] ACT_KICK        = 3'd1;
    localparam logic [2:0] ACT_SET_TIMEOUT = 3'd2;
    localparam logic [2:0] ACT_TICK        = 3'd3;
    localparam logic [2:0] ACT_QUERY       = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Slot numbers are widened to this before trimming to the result field
    localparam int SLOT_EXT_W = 7;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  client_tag;
        logic [31:0] timeout_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot_index;
        logic [7:0]  expired_mask;
        logic [31:0] average_interval;
    } out_item_t;

    // One slot of the client table as held in RAM
    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] last_kick;
        logic [31:0] timeout;
        logic [31:0] avg;
    } entry_t;

    // What kind of walk over the table an item needs
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REG  = 2'd1,
        KIND_FIND = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        kind_t in_kind;
        logic  scan_hit;
        logic  scan_end;
    } sts_t;

endpackage

// File: rtl/mtwd_ram.sv
module mtwd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
)
(
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mtwd_ctrl.sv
module mtwd_ctrl
    import mtwd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    output logic result_valid,
    input  logic result_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequence one item: accept, walk the table, update, hand off
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_kind == KIND_NONE)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_UPDATE;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    assign out_valid_next = (out_valid_reg && result_stall) || cmd.out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// File: rtl/mtwd_datapath.sv
module mtwd_datapath
    import mtwd_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t result
);

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int ENTRY_W = $bits(entry_t);

    // Control state
    logic [31:0]          time_reg, time_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 chk_live_reg, chk_live_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;

    // Item and match payload
    logic [2:0]           action_reg, action_next;
    logic [7:0]           tag_reg, tag_next;
    logic [31:0]          tmo_reg, tmo_next;
    kind_t                kind_reg, kind_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    entry_t               hit_reg, hit_next;
    logic [31:0]          avg7_reg, avg7_next;

    // Result being built and the output register
    logic [1:0]           res_status_reg, res_status_next;
    logic [2:0]           res_slot_reg, res_slot_next;
    logic [7:0]           res_mask_reg, res_mask_next;
    logic [31:0]          res_avg_reg, res_avg_next;
    out_item_t            out_reg, out_next;

    // RAM port signals
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    entry_t               ram_wr_entry;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;
    entry_t               rd_entry;

    // Scan decisions
    kind_t                in_kind;
    logic                 issue;
    logic                 chk_valid;
    logic                 cand;
    logic                 expire;
    logic                 last_slot;
    logic [31:0]          age;
    logic [SLOT_EXT_W-1:0] chk_ext;
    logic [SLOT_EXT_W-1:0] hit_ext;
    logic [31:0]          sample;
    logic [31:0]          blend;
    logic [31:0]          new_avg;

    mtwd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = entry_t'(ram_rd_data);

    // Classify the offered item
    always_comb
    begin
        case (item.action)
            ACT_TICK:
            begin
                in_kind = KIND_TICK;
            end
            ACT_REGISTER:
            begin
                in_kind = (item.client_tag == 8'd0) ? KIND_NONE : KIND_REG;
            end
            ACT_KICK, ACT_SET_TIMEOUT, ACT_QUERY:
            begin
                in_kind = (item.client_tag == 8'd0) ? KIND_NONE : KIND_FIND;
            end
            default:
            begin
                in_kind = KIND_NONE;
            end
        endcase
    end

    // Judge the slot whose entry is on the read port
    assign issue     = cmd.scan_run && (rd_cnt_reg < CNT_W'(NUM_SLOTS));
    assign ram_rd_en = issue;
    assign chk_valid = valid_reg[chk_idx_reg];
    assign age       = time_reg - rd_entry.last_kick;
    assign last_slot = (chk_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign chk_ext   = SLOT_EXT_W'(chk_idx_reg);
    assign hit_ext   = SLOT_EXT_W'(hit_idx_reg);

    always_comb
    begin
        cand   = 1'b0;
        expire = 1'b0;
        case (kind_reg)
            KIND_REG:
            begin
                cand = !chk_valid;
            end
            KIND_FIND:
            begin
                cand = chk_valid && (rd_entry.tag == tag_reg);
            end
            KIND_TICK:
            begin
                expire = chk_valid && (rd_entry.timeout != 32'd0) &&
                         (age > rd_entry.timeout);
            end
            default:
            begin
                cand = 1'b0;
            end
        endcase
    end

    assign sts.in_kind  = in_kind;
    assign sts.scan_hit = chk_live_reg && cand;
    assign sts.scan_end = chk_live_reg && last_slot;

    // Moving average of the kick interval
    assign sample  = time_reg - hit_reg.last_kick;
    assign blend   = avg7_reg + sample;
    assign new_avg = (hit_reg.avg == 32'd0) ? sample : (blend >> 3);

    always_comb
    begin
        time_next       = time_reg;
        valid_next      = valid_reg;
        rd_cnt_next     = rd_cnt_reg;
        chk_live_next   = issue;
        chk_idx_next    = rd_cnt_reg[IDX_W-1:0];
        action_next     = action_reg;
        tag_next        = tag_reg;
        tmo_next        = tmo_reg;
        kind_next       = kind_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        avg7_next       = avg7_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_mask_next   = res_mask_reg;
        res_avg_next    = res_avg_reg;
        out_next        = out_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_entry    = rd_entry;

        // Take the item, advance time on a tick, clear the result
        if (cmd.load)
        begin
            action_next     = item.action;
            tag_next        = item.client_tag;
            tmo_next        = item.timeout_ticks;
            kind_next       = in_kind;
            rd_cnt_next     = '0;
            chk_live_next   = 1'b0;
            res_slot_next   = 3'd0;
            res_mask_next   = 8'd0;
            res_avg_next    = 32'd0;
            res_status_next = STAT_OK;
            if ((item.client_tag == 8'd0) && (item.action <= ACT_QUERY) &&
                (item.action != ACT_TICK))
            begin
                res_status_next = STAT_NOT_FOUND;
            end
            if (item.action == ACT_TICK)
            begin
                time_next = time_reg + 32'd1;
            end
        end

        // Walk the table one slot a cycle
        if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        if (cmd.scan_run && chk_live_reg)
        begin
            if (expire)
            begin
                ram_wr_en              = 1'b1;
                ram_wr_addr            = chk_idx_reg;
                ram_wr_entry           = rd_entry;
                ram_wr_entry.last_kick = time_reg;
                if (chk_ext < SLOT_EXT_W'(8))
                begin
                    res_mask_next[chk_ext[2:0]] = 1'b1;
                end
            end
            if (cand)
            begin
                hit_idx_next = chk_idx_reg;
                hit_next     = rd_entry;
                avg7_next    = (rd_entry.avg << 3) - rd_entry.avg;
            end
            else if (last_slot)
            begin
                if (kind_reg == KIND_REG)
                begin
                    res_status_next = STAT_FULL;
                end
                else if (kind_reg == KIND_FIND)
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
        end

        // Apply the action to the matched slot
        if (cmd.update)
        begin
            ram_wr_addr   = hit_idx_reg;
            res_slot_next = hit_ext[2:0];
            case (action_reg)
                ACT_REGISTER:
                begin
                    ram_wr_en                 = 1'b1;
                    ram_wr_entry.tag          = tag_reg;
                    ram_wr_entry.last_kick    = time_reg;
                    ram_wr_entry.timeout      = tmo_reg;
                    ram_wr_entry.avg          = 32'd0;
                    valid_next[hit_idx_reg]   = 1'b1;
                    res_avg_next              = 32'd0;
                end
                ACT_KICK:
                begin
                    ram_wr_en              = 1'b1;
                    ram_wr_entry           = hit_reg;
                    ram_wr_entry.last_kick = time_reg;
                    ram_wr_entry.avg       = new_avg;
                    res_avg_next           = new_avg;
                end
                ACT_SET_TIMEOUT:
                begin
                    ram_wr_en            = 1'b1;
                    ram_wr_entry         = hit_reg;
                    ram_wr_entry.timeout = tmo_reg;
                    res_avg_next         = hit_reg.avg;
                end
                default:
                begin
                    res_avg_next = hit_reg.avg;
                end
            endcase
        end

        // Load the output register
        if (cmd.out_load)
        begin
            out_next.status           = res_status_reg;
            out_next.slot_index       = res_slot_reg;
            out_next.expired_mask     = res_mask_reg;
            out_next.average_interval = res_avg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= 32'd0;
            valid_reg    <= '0;
            rd_cnt_reg   <= '0;
            chk_live_reg <= 1'b0;
        end
        else
        begin
            time_reg     <= time_next;
            valid_reg    <= valid_next;
            rd_cnt_reg   <= rd_cnt_next;
            chk_live_reg <= chk_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        action_reg     <= action_next;
        tag_reg        <= tag_next;
        tmo_reg        <= tmo_next;
        kind_reg       <= kind_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        avg7_reg       <= avg7_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_mask_reg   <= res_mask_next;
        res_avg_reg    <= res_avg_next;
        out_reg        <= out_next;
    end

    assign result = out_reg;

endmodule

// File: rtl/multi_task_watchdog_monitor_unit.sv
// Watchdog over NUM_SLOTS watched clients with its own 32-bit tick count.
// Each item (register, kick, set timeout, tick, query) yields one result.
// The client table lives in one RAM that is walked one slot per cycle; a
// lookup ends early at the first matching slot, and an item with tag zero or
// an unused action code skips the walk. A tick always walks the whole table.
// A new item is taken as soon as the previous one has moved into the output
// register.
module multi_task_watchdog_monitor_unit
    import mtwd_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    cmd_t cmd;
    sts_t sts;

    mtwd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    mtwd_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

// File: sim/watchdog_result_checker.sv
`timescale 1ns / 100ps

module watchdog_result_checker
    import mtwd_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result,
    output int        mismatch_count,
    output int        results_owed
);

    // Shadow copy of the watchdog table and its tick count
    logic [31:0] tick_count;
    logic [7:0]  slot_tag   [NUM_SLOTS];
    logic [31:0] slot_stamp [NUM_SLOTS];
    logic [31:0] slot_limit [NUM_SLOTS];
    logic [31:0] slot_avg   [NUM_SLOTS];

    // Results still owed by the block, oldest first
    out_item_t expected_results[$];

    // Lowest slot holding the tag, -1 when none does
    function automatic int lowest_slot_with(input logic [7:0] tag);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_tag[i] == tag)
                return i;
        end
        return -1;
    endfunction

    // Apply one item to the shadow table and build the result it causes
    task automatic predict_watchdog(input in_item_t it, output out_item_t r);
        int          hit;
        logic [31:0] since;
        logic [31:0] blend;
        r = '0;
        if (it.action == ACT_TICK)
        begin
            // Advance time, then flag and restamp every overdue slot
            tick_count = tick_count + 32'd1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                since = tick_count - slot_stamp[i];
                if (slot_tag[i] != 8'd0 && slot_limit[i] != 32'd0 && since > slot_limit[i])
                begin
                    if (i < 8)
                        r.expired_mask[i] = 1'b1;
                    slot_stamp[i] = tick_count;
                end
            end
        end
        else if (it.action == ACT_REGISTER || it.action == ACT_KICK ||
                 it.action == ACT_SET_TIMEOUT || it.action == ACT_QUERY)
        begin
            if (it.client_tag == 8'd0)
                r.status = STAT_NOT_FOUND;
            else if (it.action == ACT_REGISTER)
            begin
                // Take the first empty slot, duplicates allowed
                hit = lowest_slot_with(8'd0);
                if (hit < 0)
                    r.status = STAT_FULL;
                else
                begin
                    slot_tag[hit]   = it.client_tag;
                    slot_limit[hit] = it.timeout_ticks;
                    slot_stamp[hit] = tick_count;
                    slot_avg[hit]   = '0;
                    r.slot_index    = hit[2:0];
                end
            end
            else
            begin
                hit = lowest_slot_with(it.client_tag);
                if (hit < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    if (it.action == ACT_KICK)
                    begin
                        // First sample seeds the average, later ones blend in at 1/8
                        since = tick_count - slot_stamp[hit];
                        if (slot_avg[hit] == 32'd0)
                            slot_avg[hit] = since;
                        else
                        begin
                            blend = slot_avg[hit] * 32'd7 + since;
                            slot_avg[hit] = blend >> 3;
                        end
                        slot_stamp[hit] = tick_count;
                    end
                    else if (it.action == ACT_SET_TIMEOUT)
                        slot_limit[hit] = it.timeout_ticks;
                    r.slot_index       = hit[2:0];
                    r.average_interval = slot_avg[hit];
                end
            end
        end
    endtask

    // Compare each result transfer, then predict each item transfer
    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        int        bad;
        if (!rst_n)
        begin
            tick_count = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_tag[i]   = '0;
                slot_stamp[i] = '0;
                slot_limit[i] = '0;
                slot_avg[i]   = '0;
            end
            expected_results.delete();
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            bad = 0;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: %h", result);
                    bad++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        bad++;
                    end
                    if (result.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, result.slot_index);
                        bad++;
                    end
                    if (result.expired_mask !== want.expired_mask)
                    begin
                        $error("expired_mask: expected %h, actual %h",
                               want.expired_mask, result.expired_mask);
                        bad++;
                    end
                    if (result.average_interval !== want.average_interval)
                    begin
                        $error("average_interval: expected %0d, actual %0d",
                               want.average_interval, result.average_interval);
                        bad++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_watchdog(item, want);
                expected_results.push_back(want);
            end
            mismatch_count <= mismatch_count + bad;
            results_owed   <= expected_results.size();
        end
    end

endmodule

// File: sim/tb_multi_task_watchdog_monitor_unit.sv
`timescale 1ns / 100ps

module tb_multi_task_watchdog_monitor_unit;
    import mtwd_pkg::*;

    localparam int NUM_SLOTS     = 8;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 150;

    // Action codes the block does not use
    localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] ACT_LAST_CODE    = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    int mismatch_count;
    int results_owed;
    int items_sent;
    int results_taken;

    // Tags the stimulus has placed in the table
    logic [7:0] watched_tags[$];

    multi_task_watchdog_monitor_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    watchdog_result_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic in_item_t make_item(input logic [2:0] act, input logic [7:0] tag,
                                           input logic [31:0] tmo);
        in_item_t it;
        it.action        = act;
        it.client_tag    = tag;
        it.timeout_ticks = tmo;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input in_item_t it);
        int gap;
        gap = ((items_sent / 120) % 5 == 2) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Draw a timeout: mostly short, sometimes disabled, long or fully random
    function automatic logic [31:0] pick_timeout();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 12);
        else if (roll < 70)
            return 32'd0;
        else if (roll < 90)
            return $urandom_range(13, 200);
        return $urandom;
    endfunction

    // Result side: random stalls, quiet stretches and two long hold-offs
    initial
    begin : result_drain
        int hold;
        result_stall  <= 1'b0;
        results_taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == 300 || results_taken == 1000)
                hold = LONG_HOLD;
            else if ((results_taken / 100) % 4 == 3)
                hold = 0;
            else
                hold = $urandom_range(0, 4);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            results_taken++;
        end
    end

    // Item side: directed opening, random traffic, then drain and verdict
    initial
    begin : item_source
        int          roll;
        int          useful;
        logic [2:0]  act;
        logic [7:0]  tag;
        logic [31:0] tmo;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tag zero, duplicate register, expiry, blending, unknown tags
        send_item(make_item(ACT_REGISTER, 8'h00, 32'd5));
        send_item(make_item(ACT_REGISTER, 8'h80, 32'd3));
        send_item(make_item(ACT_REGISTER, 8'h01, 32'd1));
        send_item(make_item(ACT_REGISTER, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_REGISTER, 8'h80, 32'd0));
        send_item(make_item(ACT_KICK, 8'h80, 32'd0));
        send_item(make_item(ACT_TICK, 8'h00, 32'd0));
        send_item(make_item(ACT_TICK, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_KICK, 8'h80, $urandom));
        send_item(make_item(ACT_TICK, 8'($urandom), $urandom));
        send_item(make_item(ACT_TICK, 8'($urandom), $urandom));
        send_item(make_item(ACT_KICK, 8'h80, $urandom));
        send_item(make_item(ACT_SET_TIMEOUT, 8'h01, 32'd0));
        send_item(make_item(ACT_QUERY, 8'hFF, $urandom));
        send_item(make_item(ACT_KICK, 8'h55, $urandom));
        send_item(make_item(ACT_SET_TIMEOUT, 8'h00, 32'hFFFF_FFFF));
        send_item(make_item(ACT_QUERY, 8'h33, $urandom));
        for (int code = ACT_FIRST_UNUSED; code <= ACT_LAST_CODE; code++)
        begin
            send_item(make_item(3'(code), 8'($urandom), $urandom));
        end
        send_item(make_item(ACT_REGISTER, 8'h10, 32'd2));
        send_item(make_item(ACT_REGISTER, 8'h20, 32'd5));
        send_item(make_item(ACT_REGISTER, 8'h30, 32'd0));
        send_item(make_item(ACT_REGISTER, 8'h40, 32'h8000_0000));
        send_item(make_item(ACT_REGISTER, 8'h11, 32'd9));
        watched_tags = '{8'h80, 8'h01, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40};

        // Random traffic, mostly on watched tags
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            tag  = watched_tags[$urandom_range(0, watched_tags.size() - 1)];
            tmo  = $urandom;
            if (roll < 35)
            begin
                act = ACT_TICK;
                tag = 8'($urandom);
            end
            else if (roll < 60)
                act = ACT_KICK;
            else if (roll < 70)
            begin
                act = ACT_SET_TIMEOUT;
                tmo = pick_timeout();
            end
            else if (roll < 82)
                act = ACT_QUERY;
            else if (roll < 87)
            begin
                act = ACT_REGISTER;
                tag = 8'($urandom_range(1, 255));
                tmo = pick_timeout();
            end
            else if (roll < 93)
            begin
                // Lookup with tag zero or a tag that is likely absent
                case ($urandom_range(0, 2))
                    0: act = ACT_KICK;
                    1: act = ACT_SET_TIMEOUT;
                    default: act = ACT_QUERY;
                endcase
                tag = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            end
            else
            begin
                act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
                tag = 8'($urandom);
            end
            send_item(make_item(act, tag, tmo));
            useful++;
        end
        item_valid <= 1'b0;

        // Drain outstanding results, then allow stragglers to show up
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("multi_task_watchdog_monitor_unit test passed");
        else
            $display("multi_task_watchdog_monitor_unit test failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin : run_limit
        #2000000;
        $display("multi_task_watchdog_monitor_unit test failed");
        $finish;
    end

endmodule
